### sv/sbb_pkg.sv
package sbb_pkg;

    localparam int MaxWidth = 1024;
    localparam int Taps     = 5;
    localparam int ColW     = $clog2(MaxWidth);
    localparam int RowW     = 17;
    localparam int SumW     = 11;
    localparam int PixW     = 24;
    localparam int OrigAw   = 13;
    localparam int OrigDepth = Taps * MaxWidth;

    localparam logic [10:0] WidthMax   = 11'd1024;
    localparam logic [10:0] WidthMin   = 11'd5;
    localparam logic [15:0] HeightMin  = 16'd5;
    localparam logic [10:0] WidthReset = 11'd640;
    localparam logic [15:0] HeightReset = 16'd480;

    localparam logic [16:0] Div5Mul = 17'd52429;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [PixW-1:0] t_pix;

    typedef struct packed {
        logic                     en;
        logic [ColW-1:0]          addr;
        t_pix                     pix;
        logic [2:0][SumW-1:0]     sum;
    } t_vbus;

    typedef struct packed {
        logic has;
        logic interior;
        logic fe;
    } t_ctrl;

    function automatic logic [7:0] div5(input logic [SumW-1:0] s);
        logic [27:0] p;
        p = {17'd0, s} * {11'd0, Div5Mul};
        return p[25:18];
    endfunction

    function automatic logic [2:0] mod5_add(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= 4'd5) begin
            t = t - 4'd5;
        end
        return t[2:0];
    endfunction

endpackage

### sv/sbb_line_cell.sv
module sbb_line_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  sbb_pkg::t_vbus i_bus,
    output sbb_pkg::t_vbus o_bus
);

    sbb_pkg::t_pix                           r_mem [0:sbb_pkg::MaxWidth-1];
    logic                                    r_en;
    logic [sbb_pkg::ColW-1:0]                r_addr;
    sbb_pkg::t_pix                           r_rd;
    logic [2:0][sbb_pkg::SumW-1:0]           r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (i_adv) begin
            r_en <= i_bus.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd   <= r_mem[i_bus.addr];
            r_addr <= i_bus.addr;
            r_sum  <= i_bus.sum;
            if (i_bus.en) begin
                r_mem[i_bus.addr] <= i_bus.pix;
            end
        end
    end

    always_comb begin
        o_bus.en   = r_en;
        o_bus.addr = r_addr;
        o_bus.pix  = r_rd;
        for (int k = 0; k < 3; k++) begin
            o_bus.sum[k] = r_sum[k] + {3'd0, r_rd[8*k +: 8]};
        end
    end

endmodule

### sv/sbb_front.sv
module sbb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_acc,
    input  sbb_pkg::t_pix  i_px,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    output sbb_pkg::t_vbus o_bus,
    output sbb_pkg::t_ctrl o_ctrl,
    output sbb_pkg::t_pix  o_orig
);

    logic [10:0]               r_width;
    logic [15:0]               r_height;
    logic [sbb_pkg::ColW-1:0]  r_col;
    logic [sbb_pkg::RowW-1:0]  r_row;
    logic [2:0]                r_rmod;
    sbb_pkg::t_pix             r_win [0:sbb_pkg::Taps-1];
    sbb_pkg::t_pix             r_orig_mem [0:sbb_pkg::OrigDepth-1];

    sbb_pkg::t_pix             r_s1_orig;
    logic                      r_s1_hw;
    logic                      r_s1_hsel;
    logic [sbb_pkg::ColW-1:0]  r_s1_c;
    sbb_pkg::t_ctrl            r_s1_ctrl;

    logic                      r_s2_hw;
    logic [sbb_pkg::ColW-1:0]  r_s2_c;
    sbb_pkg::t_pix             r_s2_h;
    sbb_pkg::t_ctrl            r_s2_ctrl;
    sbb_pkg::t_pix             r_s2_orig;

    logic [10:0]               w;
    logic [16:0]               h;
    logic [10:0]               col0;
    logic [sbb_pkg::RowW-1:0]  row0;
    logic [2:0]                m0;
    logic                      pix;
    logic                      has_pos;
    logic [sbb_pkg::RowW-1:0]  r_pos;
    logic [10:0]               c_pos;
    logic [2:0]                rbank;
    sbb_pkg::t_ctrl            ctrl0;
    logic                      hw0;
    logic                      hsel0;
    logic [10:0]               n_col;
    logic [sbb_pkg::RowW-1:0]  n_row;
    logic [2:0]                n_rmod;
    logic [10:0]               col_inc;
    sbb_pkg::t_pix             h_val;
    logic [sbb_pkg::SumW-1:0]  hsum;

    always_comb begin
        w = r_width;
        if (w > sbb_pkg::WidthMax) begin
            w = sbb_pkg::WidthMax;
        end
        if (w < sbb_pkg::WidthMin) begin
            w = sbb_pkg::WidthMin;
        end
        h = {1'b0, r_height};
        if (r_height < sbb_pkg::HeightMin) begin
            h = {1'b0, sbb_pkg::HeightMin};
        end

        col0 = {1'b0, r_col};
        row0 = r_row;
        m0   = r_rmod;
        if (col0 >= w) begin
            col0 = 11'd0;
            row0 = r_row + 17'd1;
            m0   = sbb_pkg::mod5_add(r_rmod, 3'd1);
        end
        if (row0 > h + 17'd2) begin
            row0 = '0;
            col0 = 11'd0;
            m0   = 3'd0;
        end

        pix     = row0 < h;
        has_pos = 1'b0;
        r_pos   = '0;
        rbank   = 3'd0;
        if (col0 >= 11'd2) begin
            c_pos = col0 - 11'd2;
        end else begin
            c_pos = col0 + w - 11'd2;
        end
        if (col0 >= 11'd2 && row0 >= 17'd2) begin
            has_pos = 1'b1;
            r_pos   = row0 - 17'd2;
            rbank   = sbb_pkg::mod5_add(m0, 3'd3);
        end else if (col0 < 11'd2 && row0 >= 17'd3) begin
            has_pos = 1'b1;
            r_pos   = row0 - 17'd3;
            rbank   = sbb_pkg::mod5_add(m0, 3'd2);
        end
        ctrl0.has      = has_pos && (r_pos < h);
        ctrl0.interior = (r_pos >= 17'd2) && (r_pos + 17'd2 < h);
        ctrl0.fe       = ctrl0.has && (r_pos == h - 17'd1) && (c_pos == w - 11'd1);

        hw0   = (col0 >= 11'd2 && pix) ||
                (col0 < 11'd2 && row0 >= 17'd1 && row0 <= h);
        hsel0 = col0 >= 11'd4;

        col_inc = col0 + 11'd1;
        if (col_inc >= w) begin
            n_col  = 11'd0;
            n_row  = row0 + 17'd1;
            n_rmod = sbb_pkg::mod5_add(m0, 3'd1);
        end else begin
            n_col  = col_inc;
            n_row  = row0;
            n_rmod = m0;
        end
        if (ctrl0.fe) begin
            n_col  = 11'd0;
            n_row  = '0;
            n_rmod = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sbb_pkg::WidthReset;
            r_height <= sbb_pkg::HeightReset;
            r_col    <= '0;
            r_row    <= '0;
            r_rmod   <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sbb_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                    sbb_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default:             r_width  <= r_width;
                endcase
            end
            if (i_acc) begin
                r_col  <= n_col[sbb_pkg::ColW-1:0];
                r_row  <= n_row;
                r_rmod <= n_rmod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            for (int k = 0; k < sbb_pkg::Taps - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[sbb_pkg::Taps-1] <= i_px;
            if (pix) begin
                r_orig_mem[{m0, col0[sbb_pkg::ColW-1:0]}] <= i_px;
            end
        end
        if (i_adv) begin
            r_s1_orig <= r_orig_mem[{rbank, c_pos[sbb_pkg::ColW-1:0]}];
            r_s1_hsel <= hsel0;
            r_s1_c    <= c_pos[sbb_pkg::ColW-1:0];
            r_s2_c    <= r_s1_c;
            r_s2_h    <= h_val;
            r_s2_orig <= r_s1_orig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_hw   <= 1'b0;
            r_s1_ctrl <= '0;
            r_s2_hw   <= 1'b0;
            r_s2_ctrl <= '0;
        end else if (i_adv) begin
            r_s1_hw   <= i_acc && hw0;
            r_s1_ctrl <= i_acc ? ctrl0 : '0;
            r_s2_hw   <= r_s1_hw;
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            hsum = '0;
            for (int k = 0; k < sbb_pkg::Taps; k++) begin
                hsum = hsum + {3'd0, r_win[k][8*ch +: 8]};
            end
            h_val[8*ch +: 8] = r_s1_hsel ? sbb_pkg::div5(hsum) : r_win[2][8*ch +: 8];
        end
    end

    always_comb begin
        o_bus.en   = r_s2_hw;
        o_bus.addr = r_s2_c;
        o_bus.pix  = r_s2_h;
        for (int k = 0; k < 3; k++) begin
            o_bus.sum[k] = {3'd0, r_s2_h[8*k +: 8]};
        end
        o_ctrl = r_s2_ctrl;
        o_orig = r_s2_orig;
    end

endmodule

### sv/separable_box_blur_5x5_rgb_core.sv
// Separable 5x5 box blur on an RGB raster stream. Takes one pixel per clock and
// gives one blurred pixel per clock once the pipeline is primed and while the
// output is not stalled; each result is the pixel 2*width+2 items back, so after
// the last pixel of a frame send 2*width+2 items with tuser set to drain it
// (tlast marks the last pixel out). A five-pixel shift window forms the row
// average; a chain of four line cells, each a 1024-entry line memory, forms the
// column average, with one line cell per row of vertical reach. A stalled output
// holds the whole pipeline. The user must write width and height on the cfg port
// (index 0 width, index 1 height) between frames; the block does not enforce it.
module separable_box_blur_5x5_rgb_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        i_s_axis_tuser,   // flush
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // red_out, green_out, blue_out
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic            w_adv;
    logic            w_acc;
    sbb_pkg::t_vbus  w_bus [0:4];
    sbb_pkg::t_ctrl  w_ctrl;
    sbb_pkg::t_pix   w_orig;
    sbb_pkg::t_ctrl  r_dly [0:3];
    sbb_pkg::t_pix   r_dly_orig [0:3];
    logic            r_out_v;
    sbb_pkg::t_pix   r_out_data;
    logic            r_out_last;
    sbb_pkg::t_pix   n_out_data;

    assign w_adv           = !r_out_v || i_m_axis_tready;
    assign w_acc           = w_adv && i_s_axis_tvalid;
    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    sbb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_acc       (w_acc),
        .i_px        (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bus       (w_bus[0]),
        .o_ctrl      (w_ctrl),
        .o_orig      (w_orig)
    );

    for (genvar g = 0; g < 4; g++) begin : g_line
        sbb_line_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_dly[k] <= '0;
            end
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else if (w_adv) begin
            r_dly[0] <= w_ctrl;
            for (int k = 1; k < 4; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
            r_out_v    <= r_dly[3].has;
            r_out_last <= r_dly[3].fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dly_orig[0] <= w_orig;
            for (int k = 1; k < 4; k++) begin
                r_dly_orig[k] <= r_dly_orig[k-1];
            end
            r_out_data <= n_out_data;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_out_data[8*ch +: 8] = r_dly[3].interior ? sbb_pkg::div5(w_bus[4].sum[ch])
                                                      : r_dly_orig[3][8*ch +: 8];
        end
    end

    a_interior_has_lines : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dly[3].has && r_dly[3].interior |-> w_bus[4].en)
        else $error("interior result without line data");

    a_fe_has_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dly[3].fe |-> r_dly[3].has)
        else $error("frame end without result");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_dly[3]) && $stable(w_bus[4].en))
        else $error("pipeline moved during stall");

endmodule
